@@ design/gcla_pkg.sv @@
// ----------------------------------------------------------------------------
// gcla_pkg
// Shared types and constants for the glyph cell left-align unit.
// ----------------------------------------------------------------------------
package gcla_pkg;

  localparam int PIXEL_W    = 8;
  localparam int SHIFT_W    = 5;
  localparam int CFG_DATA_W = 6;
  localparam int CFG_IDX_W  = 1;

  // Register indexes on the write port
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_HEIGHT = 1'b1;

  localparam logic [CFG_DATA_W-1:0] CFG_WIDTH_RESET  = 6'd16;
  localparam logic [CFG_DATA_W-1:0] CFG_HEIGHT_RESET = 6'd16;

  // Item kinds
  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_DRAIN = 1'b1;

  typedef logic [PIXEL_W-1:0] pixel_t;

  // Side info carried alongside a pending store read
  typedef struct packed {
    logic               zero_fill;
    logic [SHIFT_W-1:0] shift;
    logic               last;
  } drain_info_t;

endpackage

@@ design/gcla_ram.sv @@
// ----------------------------------------------------------------------------
// gcla_ram
// Generic single-clock RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module gcla_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ design/glyph_cell_left_align_unit.sv @@
// ----------------------------------------------------------------------------
// glyph_cell_left_align_unit
// Loads one grayscale glyph cell into a store, tracks the leftmost inked
// column, then drains the cell left-aligned in raster order.
// ----------------------------------------------------------------------------
//
//  channel   | handshake                | payload
//  ----------+--------------------------+--------------------------------------
//  item in   | start & !busy            | kind, pixel_in
//  result    | done (one-cycle strobe)  | pixel_out, shift_used, last_pixel
//  config    | cfg_we                   | cfg_index, cfg_wdata
//
//  Busy stays low, so an item can be accepted on every clock. A drain
//  item reads the cell store (one read port, registered read) and its
//  result is strobed on done in the following cycle.
//  Load items write the store through its write port and give no result.
//  Reset (rst, synchronous) clears counters and flags; the store itself is
//  not cleared, since drains only read entries loaded for the current cell.
//  Results cannot be held off by the receiver, so nothing ever backs up.
//
module glyph_cell_left_align_unit #(
  parameter int MAX_CELL_WIDTH  = 32,
  parameter int MAX_CELL_HEIGHT = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  // item in
  input  logic                              start,
  output logic                              busy,
  input  logic                              kind,
  input  logic [gcla_pkg::PIXEL_W-1:0]      pixel_in,
  // result
  output logic                              done,
  output logic [gcla_pkg::PIXEL_W-1:0]      pixel_out,
  output logic [gcla_pkg::SHIFT_W-1:0]      shift_used,
  output logic                              last_pixel,
  // config
  input  logic                              cfg_we,
  input  logic [gcla_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [gcla_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  import gcla_pkg::*;

  localparam int CW    = $clog2(MAX_CELL_WIDTH);                         // column bits
  localparam int RW    = (MAX_CELL_HEIGHT > 1) ? $clog2(MAX_CELL_HEIGHT) : 1;
  localparam int EW    = $clog2(MAX_CELL_WIDTH + 1);                     // eff width bits
  localparam int EH    = $clog2(MAX_CELL_HEIGHT + 1);
  localparam int DEPTH = MAX_CELL_WIDTH * MAX_CELL_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int CMPW  = CFG_DATA_W + 1;                                 // room for max 64

  // Config registers
  logic [CFG_DATA_W-1:0] cell_width, cell_height;

  // Cell position (shared by load and drain: load ends at 0,0 where drain begins)
  logic [CW-1:0] pos_col, pos_col_next;
  logic [RW-1:0] pos_row, pos_row_next;
  logic [CW-1:0] leftmost_col, leftmost_col_next;
  logic          any_ink, any_ink_next;
  logic          cell_ready, cell_ready_next;

  // Pending drain result
  logic          done_next;
  drain_info_t   info, info_next;

  // Store ports
  logic          mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  pixel_t        mem_rdata;

  // Effective geometry: 0 reads as 1, large values saturate
  logic [EW-1:0] eff_w;
  logic [EH-1:0] eff_h;

  always_comb begin
    if (cell_width == '0) begin
      eff_w = EW'(1);
    end else if ({1'b0, cell_width} > CMPW'(MAX_CELL_WIDTH)) begin
      eff_w = EW'(MAX_CELL_WIDTH);
    end else begin
      eff_w = EW'(cell_width);
    end
    if (cell_height == '0) begin
      eff_h = EH'(1);
    end else if ({1'b0, cell_height} > CMPW'(MAX_CELL_HEIGHT)) begin
      eff_h = EH'(MAX_CELL_HEIGHT);
    end else begin
      eff_h = EH'(cell_height);
    end
  end

  logic          at_row_end, at_cell_end;
  logic [CW-1:0] shift;
  logic [CW:0]   src_col;
  logic          src_ok;
  logic          accept;

  assign accept      = start && !busy;
  assign at_row_end  = (EW'(pos_col) == EW'(eff_w - EW'(1)));
  assign at_cell_end = at_row_end && (pos_row == RW'(eff_h - EH'(1)));
  assign shift       = any_ink ? leftmost_col : '0;
  assign src_col     = (CW+1)'(pos_col) + (CW+1)'(shift);
  assign src_ok      = (src_col < (CW+1)'(eff_w));

  // Raster address of row/column in the store (constant multiply)
  assign mem_waddr = AW'(AW'(pos_row) * AW'(MAX_CELL_WIDTH)) + AW'(pos_col);
  assign mem_raddr = AW'(AW'(pos_row) * AW'(MAX_CELL_WIDTH)) + AW'(src_col[CW-1:0]);

  always_comb begin
    pos_col_next      = pos_col;
    pos_row_next      = pos_row;
    leftmost_col_next = leftmost_col;
    any_ink_next      = any_ink;
    cell_ready_next   = cell_ready;
    mem_we            = 1'b0;
    done_next         = 1'b0;
    info_next         = info;

    if (cfg_we) begin
      // any register write aborts the cell in progress
      pos_col_next      = '0;
      pos_row_next      = '0;
      leftmost_col_next = '0;
      any_ink_next      = 1'b0;
      cell_ready_next   = 1'b0;
    end else if (accept && kind == KIND_LOAD && !cell_ready) begin
      mem_we = 1'b1;
      if (pixel_in != '0) begin
        if (!any_ink || pos_col < leftmost_col) begin
          leftmost_col_next = pos_col;
        end
        any_ink_next = 1'b1;
      end
      if (at_row_end) begin
        pos_col_next = '0;
        if (at_cell_end) begin
          pos_row_next    = '0;
          cell_ready_next = 1'b1;
        end else begin
          pos_row_next = pos_row + RW'(1);
        end
      end else begin
        pos_col_next = pos_col + CW'(1);
      end
    end else if (accept && kind == KIND_DRAIN && cell_ready) begin
      done_next           = 1'b1;
      info_next.zero_fill = !src_ok;
      info_next.shift     = SHIFT_W'(shift);
      info_next.last      = at_cell_end;
      if (at_cell_end) begin
        pos_col_next      = '0;
        pos_row_next      = '0;
        leftmost_col_next = '0;
        any_ink_next      = 1'b0;
        cell_ready_next   = 1'b0;
      end else if (at_row_end) begin
        pos_col_next = '0;
        pos_row_next = pos_row + RW'(1);
      end else begin
        pos_col_next = pos_col + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cell_width   <= CFG_WIDTH_RESET;
      cell_height  <= CFG_HEIGHT_RESET;
      pos_col      <= '0;
      pos_row      <= '0;
      leftmost_col <= '0;
      any_ink      <= 1'b0;
      cell_ready   <= 1'b0;
      done         <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_IDX_WIDTH:  cell_width  <= cfg_wdata;
          CFG_IDX_HEIGHT: cell_height <= cfg_wdata;
          default: ;
        endcase
      end
      pos_col      <= pos_col_next;
      pos_row      <= pos_row_next;
      leftmost_col <= leftmost_col_next;
      any_ink      <= any_ink_next;
      cell_ready   <= cell_ready_next;
      done         <= done_next;
    end
  end

  // payload side info, no reset needed
  always_ff @(posedge clk) begin
    info <= info_next;
  end

  gcla_ram #(
    .WIDTH (PIXEL_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (pixel_in),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // never stalls: busy is tied low
  assign busy       = 1'b0;
  assign pixel_out  = info.zero_fill ? '0 : mem_rdata;
  assign shift_used = info.shift;
  assign last_pixel = info.last;

endmodule

@@ design/gcla_checker.sv @@
// ----------------------------------------------------------------------------
// gcla_props
// Port-level checks on item and result timing of the left-align unit.
// ----------------------------------------------------------------------------
module gcla_props (
  input logic                            clk,
  input logic                            rst,
  input logic                            start,
  input logic                            busy,
  input logic                            kind,
  input logic                            done,
  input logic [gcla_pkg::SHIFT_W-1:0]    shift_used,
  input logic                            last_pixel
);

  import gcla_pkg::*;

  // a result only follows a drain accepted in the cycle before
  a_done_after_drain: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy && kind == KIND_DRAIN))
    else $error("result without a preceding drain item");

  // a load never produces a result
  a_load_silent: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && kind == KIND_LOAD) |=> !done)
    else $error("result after a load item");

  // the cell ends with its last pixel; nothing more drains right after
  a_quiet_after_last: assert property (@(posedge clk) disable iff (rst)
    (done && last_pixel) |=> !done)
    else $error("result right after the last pixel of a cell");

  // shift is fixed for all pixels of one cell
  a_shift_steady: assert property (@(posedge clk) disable iff (rst)
    (done && !last_pixel) ##1 done |-> $stable(shift_used))
    else $error("shift changed within a cell");

endmodule

bind glyph_cell_left_align_unit gcla_props u_gcla_checker (
  .clk        (clk),
  .rst        (rst),
  .start      (start),
  .busy       (busy),
  .kind       (kind),
  .done       (done),
  .shift_used (shift_used),
  .last_pixel (last_pixel)
);
